### hdl/acsd_pkg.sv
// shared types, character constants and helpers for the alignment column snp detector
`timescale 1ns / 1ps
`default_nettype none

package acsd_pkg;

    localparam logic [7:0] CHAR_GAP   = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_N_UP  = 8'h4E;  // 'N'
    localparam logic [7:0] CHAR_N_LOW = 8'h6E;  // 'n'
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic [7:0] ref_char;
        logic       ref_searching;
        logic       verdict_fixed;
        logic       snp_seen;
        logic       mid_column;
    } col_state_t;

    typedef struct packed {
        logic       has_snp;
        logic [7:0] resolved_reference;
    } col_result_t;

    function automatic logic is_terminator(input logic [7:0] c);
        is_terminator = (c == CHAR_NUL) || (c == CHAR_LF);
    endfunction

    function automatic logic is_gap_or_n(input logic [7:0] c);
        is_gap_or_n = (c == CHAR_GAP) || (c == CHAR_N_UP) || (c == CHAR_N_LOW);
    endfunction

endpackage

`default_nettype wire

### hdl/acsd_col_update.sv
// per-sample update of the column state: reference resolution and snp verdict
`timescale 1ns / 1ps
`default_nettype none

module acsd_col_update
(
    input  wire acsd_pkg::col_state_t  cur,
    input  wire logic [7:0]            base,
    input  wire logic                  is_internal,
    input  wire logic [7:0]            column_ref,
    output acsd_pkg::col_state_t       nxt,
    output acsd_pkg::col_result_t      res
);

    logic       first;
    logic [7:0] ref0;
    logic       search0;
    logic       fixed0;
    logic       snp0;
    logic       term;
    logic       real_base;
    logic [7:0] ref1;
    logic       fixed1;
    logic       snp1;

    always_comb
    begin
        first     = !cur.mid_column;
        // reference is sampled only from the first item of a column
        ref0      = first ? column_ref : cur.ref_char;
        search0   = first ? acsd_pkg::is_gap_or_n(column_ref) : cur.ref_searching;
        fixed0    = first ? 1'b0 : cur.verdict_fixed;
        snp0      = first ? 1'b0 : cur.snp_seen;

        term      = acsd_pkg::is_terminator(base);
        real_base = !term && !acsd_pkg::is_gap_or_n(base);

        ref1      = (search0 && real_base) ? base : ref0;

        fixed1    = fixed0;
        snp1      = snp0;
        if (!fixed0 && !is_internal)
        begin
            if (term)
            begin
                fixed1 = 1'b1;
            end
            else if (real_base && (base != ref1))
            begin
                snp1   = 1'b1;
                fixed1 = 1'b1;
            end
        end

        nxt.ref_char      = ref1;
        nxt.ref_searching = search0 && !term && !real_base;
        nxt.verdict_fixed = fixed1;
        nxt.snp_seen      = snp1;
        nxt.mid_column    = 1'b1;

        res.has_snp            = snp1;
        res.resolved_reference = ref1;
    end

endmodule

`default_nettype wire

### hdl/alignment_column_snp_detector_core.sv
// alignment column snp detector top level: column state, result register and handshakes
//
//  channel | dir | tdata                                   | tuser          | tlast
//  s_*     | in  | [7:0] base, [15:8] column_ref            | [0] is_internal | last_in_column
//  m_*     | out | [7:0] resolved_reference                | [0] has_snp     | -
//
// one sample per cycle while s_tready is high; column state updates on each accepted request
// a result appears in the cycle after the last sample of a column is taken
// the result register frees in the same cycle it is taken, so columns stream with no gap
// s_tready drops only while a result waits and m_tready is low
// reset clears the column state and the output valid
`timescale 1ns / 1ps
`default_nettype none

module alignment_column_snp_detector_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] base, [15:8] column_ref
    input  wire logic [0:0]  s_tuser,   // [0] is_internal
    input  wire logic        s_tlast,   // last_in_column
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] resolved_reference
    output logic [0:0]       m_tuser    // [0] has_snp
);

    localparam acsd_pkg::col_state_t COL_RESET = '{
        ref_char:      8'h00,
        ref_searching: 1'b1,
        verdict_fixed: 1'b0,
        snp_seen:      1'b0,
        mid_column:    1'b0
    };

    acsd_pkg::col_state_t  col_reg;
    acsd_pkg::col_state_t  col_next;
    acsd_pkg::col_state_t  col_upd;
    acsd_pkg::col_result_t col_res;
    acsd_pkg::col_result_t res_reg;
    logic                  out_valid_reg;
    logic                  in_accept;

    acsd_col_update u_update
    (
        .cur         (col_reg),
        .base        (s_tdata[7:0]),
        .is_internal (s_tuser[0]),
        .column_ref  (s_tdata[15:8]),
        .nxt         (col_upd),
        .res         (col_res)
    );

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg;
        if (in_accept)
        begin
            // a closed column returns to the start state
            col_next = s_tlast ? COL_RESET : col_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= COL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            if (in_accept && s_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (in_accept && s_tlast)
        begin
            res_reg <= col_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg.resolved_reference;
    assign m_tuser  = res_reg.has_snp;

endmodule

`default_nettype wire

### hdl/acsd_checker.sv
// port-level checks for the alignment column snp detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module acsd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a column close always produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after column close");

    // no result without a column close
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && s_tlast) && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("result appeared without a column close");

    // input stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with free result register");

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind alignment_column_snp_detector_core acsd_checker u_acsd_checker (.*);

`default_nettype wire

### test/acsd_column_checker.sv
// checker for the alignment column snp detector: predicts each column verdict and compares
`timescale 1ns / 1ps

module acsd_column_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] base, [15:8] column_ref
    input  wire logic [0:0]  s_tuser,   // [0] is_internal
    input  wire logic        s_tlast,   // last_in_column
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] resolved_reference
    input  wire logic [0:0]  m_tuser,   // [0] has_snp
    output int               errors,
    output int               pending
);

    // predicted column state
    logic [7:0]  col_ref;
    logic        ref_open;
    logic        verdict_done;
    logic        snp_found;
    logic        in_column;

    acsd_pkg::col_result_t column_verdicts[$];
    acsd_pkg::col_result_t want;

    function automatic logic is_wildcard(input logic [7:0] c);
        return (c == acsd_pkg::CHAR_GAP) || (c == acsd_pkg::CHAR_N_UP) ||
               (c == acsd_pkg::CHAR_N_LOW);
    endfunction

    task automatic clear_column();
        col_ref      = 8'h00;
        ref_open     = 1'b1;
        verdict_done = 1'b0;
        snp_found    = 1'b0;
        in_column    = 1'b0;
    endtask

    // advance the column state by one sample, queue a verdict on the closing one
    task automatic predict_sample(input logic [7:0] b, input logic internal,
                                  input logic [7:0] rb, input logic closes);
        logic                  stop;
        logic                  real_base;
        acsd_pkg::col_result_t verdict;
        stop      = (b == acsd_pkg::CHAR_NUL) || (b == acsd_pkg::CHAR_LF);
        real_base = !stop && !is_wildcard(b);
        if (!in_column)
        begin
            col_ref      = rb;
            ref_open     = is_wildcard(rb);
            verdict_done = 1'b0;
            snp_found    = 1'b0;
            in_column    = 1'b1;
        end
        // internal nodes still take part in resolving the reference
        if (ref_open)
        begin
            if (stop)
                ref_open = 1'b0;
            else if (real_base)
            begin
                col_ref  = b;
                ref_open = 1'b0;
            end
        end
        if (!verdict_done && !internal)
        begin
            if (stop)
                verdict_done = 1'b1;
            else if (real_base && b != col_ref)
            begin
                snp_found    = 1'b1;
                verdict_done = 1'b1;
            end
        end
        if (closes)
        begin
            verdict.has_snp            = snp_found;
            verdict.resolved_reference = col_ref;
            column_verdicts.push_back(verdict);
            clear_column();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_column();
            column_verdicts.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_sample(s_tdata[7:0], s_tuser[0], s_tdata[15:8], s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (column_verdicts.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual has_snp %0b ref %02h",
                             $time, m_tuser[0], m_tdata);
                end
                else
                begin
                    want = column_verdicts.pop_front();
                    if (m_tuser[0] !== want.has_snp)
                    begin
                        errors++;
                        $display("%0t: has_snp mismatch: expected %0b, actual %0b",
                                 $time, want.has_snp, m_tuser[0]);
                    end
                    if (m_tdata !== want.resolved_reference)
                    begin
                        errors++;
                        $display("%0t: resolved_reference mismatch: expected %02h, actual %02h",
                                 $time, want.resolved_reference, m_tdata);
                    end
                end
            end
        end
        pending = column_verdicts.size();
    end

endmodule

### test/alignment_column_snp_detector_core_tb.sv
// testbench top for the alignment column snp detector: stimulus, reset and verdict
`timescale 1ns / 1ps

module alignment_column_snp_detector_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    int errors;
    int pending;
    int cycle_count = 0;
    int samples_sent = 0;
    logic steady;

    // a stretch of requests where neither side idles
    assign steady = (samples_sent >= 600) && (samples_sent < 900);

    alignment_column_snp_detector_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    acsd_column_checker u_column_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("alignment_column_snp_detector_core_tb failed");
        $finish;
    end

    task automatic send_sample(input logic [7:0] b, input logic internal,
                               input logic [7:0] rb, input logic closes);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rb, b};
        s_tuser  <= internal;
        s_tlast  <= closes;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    function automatic logic [7:0] pick_nucleotide();
        case ($urandom_range(0, 3))
            0: return "A";
            1: return "C";
            2: return "G";
            default: return "T";
        endcase
    endfunction

    function automatic logic [7:0] pick_reference();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return pick_nucleotide();
        else if (roll < 60)
            return acsd_pkg::CHAR_GAP;
        else if (roll < 70)
            return acsd_pkg::CHAR_N_UP;
        else if (roll < 78)
            return acsd_pkg::CHAR_N_LOW;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_base(input logic [7:0] col_ref);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return col_ref;
        else if (roll < 55)
            return pick_nucleotide();
        else if (roll < 63)
            return acsd_pkg::CHAR_GAP;
        else if (roll < 68)
            return acsd_pkg::CHAR_N_UP;
        else if (roll < 72)
            return acsd_pkg::CHAR_N_LOW;
        else if (roll < 76)
            return acsd_pkg::CHAR_NUL;
        else if (roll < 80)
            return acsd_pkg::CHAR_LF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // sink side: random backpressure plus one long hold-off to fill the block
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && samples_sent >= 400)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    initial
    begin
        int len;
        logic [7:0] col_ref;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-sample columns, resolving sample, terminator stopping the search
        send_sample("A", 1'b0, "A", 1'b1);
        send_sample("C", 1'b0, acsd_pkg::CHAR_GAP, 1'b1);
        send_sample(acsd_pkg::CHAR_NUL, 1'b0, acsd_pkg::CHAR_N_LOW, 1'b1);
        send_sample(acsd_pkg::CHAR_NUL, 1'b0, acsd_pkg::CHAR_NUL, 1'b1);
        // internal node differing, then a match
        send_sample("T", 1'b1, "G", 1'b0);
        send_sample("G", 1'b0, "T", 1'b1);
        // internal node resolves the reference, later reference bytes ignored
        send_sample("A", 1'b1, acsd_pkg::CHAR_N_UP, 1'b0);
        send_sample("C", 1'b0, "C", 1'b1);
        // newline fixes the verdict, later difference has no effect
        send_sample(acsd_pkg::CHAR_LF, 1'b0, "A", 1'b0);
        send_sample("T", 1'b0, "T", 1'b1);
        // unresolved reference: internal terminator stops search, real base is a snp
        send_sample(acsd_pkg::CHAR_N_UP, 1'b0, acsd_pkg::CHAR_GAP, 1'b0);
        send_sample(acsd_pkg::CHAR_NUL, 1'b1, acsd_pkg::CHAR_GAP, 1'b0);
        send_sample("A", 1'b0, "A", 1'b1);
        // high bytes count as real bases
        send_sample(8'h80, 1'b0, 8'hFF, 1'b0);
        send_sample(8'hFF, 1'b1, 8'h00, 1'b1);
        send_sample(8'hFF, 1'b0, 8'hFF, 1'b1);

        while (samples_sent < RANDOM_ITEMS + 16)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            col_ref = pick_reference();
            for (int k = 0; k < len; k++)
                send_sample(pick_base(col_ref), $urandom_range(0, 3) == 0,
                            (k == 0) ? col_ref : 8'($urandom_range(0, 255)), k == len - 1);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("alignment_column_snp_detector_core_tb passed");
        else
            $display("alignment_column_snp_detector_core_tb failed");
        $finish;
    end

endmodule
